FILE: hw/rtl/bpc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_pkg
// Shared types, widths and constants of the binned pair covariance core.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int WIN_DEPTH   = 256;
    localparam int WIN_AW      = $clog2(WIN_DEPTH);
    localparam int WIN_FILL_W  = WIN_AW + 1;
    localparam int NUM_BINS    = 1024;
    localparam int BIN_AW      = $clog2(NUM_BINS);
    localparam int DCNT_W      = $clog2(BIN_AW);

    localparam int OP_W        = 2;
    localparam int CHROM_W     = 6;
    localparam int POS_W       = 32;
    localparam int GT_W        = 3;
    localparam int EG_W        = 2;
    localparam int SEL_W       = 10;

    localparam int PC_W        = 32;
    localparam int SP_W        = 36;
    localparam int SF_W        = 34;
    localparam int COV_W       = 20;

    localparam int BW_W        = 20;
    localparam int MD_W        = 24;

    localparam int WENT_W      = CHROM_W + POS_W + EG_W;
    localparam int BENT_W      = PC_W + SP_W + SF_W + SF_W;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;

    localparam logic [BW_W-1:0]    BIN_WIDTH_RST = BW_W'(1000);
    localparam logic [MD_W-1:0]    MAX_DIST_RST  = MD_W'(1000000);
    localparam logic [CHROM_W-1:0] NUM_CHROM_RST = CHROM_W'(22);

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 2'd0,
        OP_READ  = 2'd1,
        OP_CLEAR = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BIN_WIDTH = 3'd0,
        CFG_MAX_DIST  = 3'd1,
        CFG_EXCL      = 3'd2,
        CFG_LEFT_OUT  = 3'd3,
        CFG_NUM_CHROM = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WIN_RD,
        ST_WIN_EV,
        ST_BIN_DIV,
        ST_BIN_RD,
        ST_BIN_WR,
        ST_STORE,
        ST_READ_RD,
        ST_READ_EV,
        ST_COV,
        ST_DONE
    } t_state;

    typedef enum logic [3:0] {
        CV_IDLE,
        CV_MUL_A,
        CV_SAVE_A,
        CV_MUL_B,
        CV_SAVE_B,
        CV_MUL_D,
        CV_SAVE_D,
        CV_DIV,
        CV_ROUND
    } t_cov_state;

endpackage
`default_nettype wire

FILE: hw/rtl/binned_pair_covariance_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// binned_pair_covariance_core
// Marker window in one RAM, per-bin accumulators in another; each new marker
// is paired against the window one entry per step.
// ----------------------------------------------------------------------------
// Add: each window entry is evaluated in turn; each counted pair adds a 10-step
//   bin division, a bin read and a bin write.
// Read: a bin read, optionally with covariance (three 34-step products,
//   84-step division). Clear: one bin written per cycle.
// Reset: synchronous; a clearing pass of the bin RAM follows
//   during which no item is taken. One item is worked at a time.
// ----------------------------------------------------------------------------
module binned_pair_covariance_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic        [bpc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic        [bpc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    input  wire logic        [bpc_pkg::OP_W-1:0]       i_op,
    input  wire logic        [bpc_pkg::CHROM_W-1:0]    i_chromosome,
    input  wire logic        [bpc_pkg::POS_W-1:0]      i_position,
    input  wire logic signed [bpc_pkg::GT_W-1:0]       i_genotype,
    input  wire logic                                i_marker_ignored,
    input  wire logic        [bpc_pkg::SEL_W-1:0]      i_bin_select,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output logic             [bpc_pkg::PC_W-1:0]       o_pair_count,
    output logic             [bpc_pkg::SP_W-1:0]       o_sum_product,
    output logic             [bpc_pkg::SF_W-1:0]       o_sum_first,
    output logic             [bpc_pkg::SF_W-1:0]       o_sum_second,
    output logic signed      [bpc_pkg::COV_W-1:0]      o_covariance,
    output logic                                     o_covariance_valid,
    output logic                                     o_window_overflow,
    output logic                                     o_bin_overflow
);
    import bpc_pkg::*;

    t_state r_state, n_state;

    logic [BW_W-1:0]       r_bin_width;
    logic [MD_W-1:0]       r_max_span;
    logic [CHROM_W-1:0]    r_excl;
    logic [CHROM_W-1:0]    r_left_out;
    logic [CHROM_W-1:0]    r_num_chrom;

    logic [WIN_AW-1:0]     r_head;
    logic [WIN_FILL_W-1:0] r_fill;
    logic [WIN_AW-1:0]     r_k;
    logic                  r_wflag;
    logic                  r_bflag;
    logic [BIN_AW-1:0]     r_clr_addr;
    logic                  r_clr_op;
    logic                  r_out_valid;
    logic                  r_cov_start;

    logic [CHROM_W-1:0]    r_chrom;
    logic [POS_W-1:0]      r_pos;
    logic [EG_W-1:0]       r_gt;
    logic [SEL_W-1:0]      r_sel;
    logic [EG_W-1:0]       r_eg;
    logic [MD_W-1:0]       r_drem;
    logic [BW_W+BIN_AW-1:0] r_dsor;
    logic [BIN_AW-1:0]     r_quo;
    logic [DCNT_W-1:0]     r_dcnt;

    logic [PC_W-1:0]       r_res_pc;
    logic [SP_W-1:0]       r_res_sp;
    logic [SF_W-1:0]       r_res_sa;
    logic [SF_W-1:0]       r_res_sb;
    logic signed [COV_W-1:0] r_res_cov;
    logic                  r_res_cv;

    logic [PC_W-1:0]       r_out_pc;
    logic [SP_W-1:0]       r_out_sp;
    logic [SF_W-1:0]       r_out_sa;
    logic [SF_W-1:0]       r_out_sb;
    logic signed [COV_W-1:0] r_out_cov;
    logic                  r_out_cv;
    logic                  r_out_wf;
    logic                  r_out_bf;

    logic                  in_xfer;
    logic                  add_skip;
    logic                  last_entry;
    logic                  out_load;

    logic [WIN_AW-1:0]     win_raddr;
    logic                  win_we;
    logic [WENT_W-1:0]     win_wdata;
    logic [WENT_W-1:0]     win_rdata;

    logic [CHROM_W-1:0]    e_chrom;
    logic [POS_W-1:0]      e_pos;
    logic [EG_W-1:0]       e_gt;
    logic [POS_W-1:0]      delta;
    logic                  pair_hit;
    logic                  bin_past;
    logic [BW_W-1:0]       bw_eff;

    logic [BIN_AW-1:0]     bin_raddr;
    logic [BIN_AW-1:0]     bin_waddr;
    logic                  bin_we;
    logic [BENT_W-1:0]     bin_wdata;
    logic [BENT_W-1:0]     bin_rdata;

    logic [PC_W-1:0]       b_pc;
    logic [SP_W-1:0]       b_sp;
    logic [SF_W-1:0]       b_sa;
    logic [SF_W-1:0]       b_sb;
    logic [PC_W:0]         s_pc;
    logic [SP_W:0]         s_sp;
    logic [SF_W:0]         s_sa;
    logic [SF_W:0]         s_sb;
    logic                  sel_ok;
    logic                  div_ge;

    logic                  cov_need;
    logic                  cov_done;
    logic signed [COV_W-1:0] cov_val;

    assign in_xfer  = i_in_valid && (r_state == ST_IDLE);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    assign add_skip = i_marker_ignored || ($unsigned(i_genotype) > GT_W'(2)) ||
                      (i_chromosome == '0) || (i_chromosome > r_num_chrom) ||
                      (i_chromosome == r_excl) || (i_chromosome == r_left_out);

    assign last_entry = ({1'b0, r_k} + WIN_FILL_W'(1) == r_fill);

    assign e_chrom  = win_rdata[WENT_W-1 -: CHROM_W];
    assign e_pos    = win_rdata[EG_W +: POS_W];
    assign e_gt     = win_rdata[EG_W-1:0];
    assign delta    = r_pos - e_pos;
    assign pair_hit = (e_chrom == r_chrom) && (e_pos <= r_pos) &&
                      (delta < POS_W'(r_max_span));
    assign bw_eff   = (r_bin_width == '0) ? BW_W'(1) : r_bin_width;
    assign bin_past = (delta >= POS_W'({bw_eff, {BIN_AW{1'b0}}}));
    assign div_ge   = ((BW_W+BIN_AW)'(r_drem) >= r_dsor);

    assign win_raddr = r_head - r_fill[WIN_AW-1:0] + r_k;
    assign win_we    = (r_state == ST_STORE);
    assign win_wdata = {r_chrom, r_pos, r_gt};

    assign {b_pc, b_sp, b_sa, b_sb} = bin_rdata;
    assign s_pc = {1'b0, b_pc} + (PC_W+1)'(1);
    assign s_sp = {1'b0, b_sp} + (SP_W+1)'({2'b00, r_eg} * {2'b00, r_gt});
    assign s_sa = {1'b0, b_sa} + (SF_W+1)'(r_eg);
    assign s_sb = {1'b0, b_sb} + (SF_W+1)'(r_gt);

    assign bin_raddr = (r_state == ST_READ_RD) ? r_sel[BIN_AW-1:0] : r_quo;
    assign bin_waddr = (r_state == ST_CLEAR) ? r_clr_addr : r_quo;
    assign bin_we    = (r_state == ST_CLEAR) || (r_state == ST_BIN_WR);
    assign bin_wdata = (r_state == ST_CLEAR) ? '0 :
                       {s_pc[PC_W] ? {PC_W{1'b1}} : s_pc[PC_W-1:0],
                        s_sp[SP_W] ? {SP_W{1'b1}} : s_sp[SP_W-1:0],
                        s_sa[SF_W] ? {SF_W{1'b1}} : s_sa[SF_W-1:0],
                        s_sb[SF_W] ? {SF_W{1'b1}} : s_sb[SF_W-1:0]};

    assign sel_ok    = (32'(r_sel) < NUM_BINS);
    assign cov_need  = (r_state == ST_READ_EV) && sel_ok && (b_pc >= PC_W'(2));

    bpc_ram #(
        .WIDTH (WENT_W),
        .DEPTH (WIN_DEPTH)
    ) u_win_ram (
        .i_clk   (i_clk),
        .i_we    (win_we),
        .i_waddr (r_head),
        .i_wdata (win_wdata),
        .i_raddr (win_raddr),
        .o_rdata (win_rdata)
    );

    bpc_ram #(
        .WIDTH (BENT_W),
        .DEPTH (NUM_BINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (bin_we),
        .i_waddr (bin_waddr),
        .i_wdata (bin_wdata),
        .i_raddr (bin_raddr),
        .o_rdata (bin_rdata)
    );

    bpc_cov u_cov (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_cov_start),
        .i_pairs       (r_res_pc),
        .i_sum_product (r_res_sp),
        .i_sum_first   (r_res_sa),
        .i_sum_second  (r_res_sb),
        .o_done        (cov_done),
        .o_covariance  (cov_val)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == BIN_AW'(NUM_BINS - 1)) begin
                    n_state = r_clr_op ? ST_DONE : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    unique case (t_op'(i_op))
                        OP_ADD: begin
                            if (add_skip) begin
                                n_state = ST_DONE;
                            end else if (r_fill == '0) begin
                                n_state = ST_STORE;
                            end else begin
                                n_state = ST_WIN_RD;
                            end
                        end
                        OP_READ:  n_state = ST_READ_RD;
                        OP_CLEAR: n_state = ST_CLEAR;
                        default:  n_state = ST_DONE;
                    endcase
                end
            end
            ST_WIN_RD: n_state = ST_WIN_EV;
            ST_WIN_EV: begin
                if (pair_hit && !bin_past) begin
                    n_state = ST_BIN_DIV;
                end else begin
                    n_state = last_entry ? ST_STORE : ST_WIN_RD;
                end
            end
            ST_BIN_DIV: if (r_dcnt == DCNT_W'(BIN_AW - 1)) n_state = ST_BIN_RD;
            ST_BIN_RD:  n_state = ST_BIN_WR;
            ST_BIN_WR:  n_state = last_entry ? ST_STORE : ST_WIN_RD;
            ST_STORE:   n_state = ST_DONE;
            ST_READ_RD: n_state = ST_READ_EV;
            ST_READ_EV: n_state = cov_need ? ST_COV : ST_DONE;
            ST_COV:     if (cov_done) n_state = ST_DONE;
            ST_DONE:    if (!r_out_valid || i_out_ready) n_state = ST_IDLE;
            default:    n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_width <= BIN_WIDTH_RST;
            r_max_span  <= MAX_DIST_RST;
            r_excl      <= '0;
            r_left_out  <= '0;
            r_num_chrom <= NUM_CHROM_RST;
            r_head      <= '0;
            r_fill      <= '0;
            r_k         <= '0;
            r_wflag     <= 1'b0;
            r_bflag     <= 1'b0;
            r_clr_addr  <= '0;
            r_clr_op    <= 1'b0;
            r_out_valid <= 1'b0;
            r_cov_start <= 1'b0;
        end else begin
            r_cov_start <= cov_need;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_BIN_WIDTH: r_bin_width <= i_cfg_data[BW_W-1:0];
                    CFG_MAX_DIST:  r_max_span  <= i_cfg_data[MD_W-1:0];
                    CFG_EXCL:      r_excl      <= i_cfg_data[CHROM_W-1:0];
                    CFG_LEFT_OUT:  r_left_out  <= i_cfg_data[CHROM_W-1:0];
                    CFG_NUM_CHROM: r_num_chrom <= i_cfg_data[CHROM_W-1:0];
                    default: ;
                endcase
            end

            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + BIN_AW'(1);
            end

            if (in_xfer) begin
                r_k <= '0;
                if (t_op'(i_op) == OP_CLEAR) begin
                    r_clr_op   <= 1'b1;
                    r_clr_addr <= '0;
                    r_head     <= '0;
                    r_fill     <= '0;
                    r_wflag    <= 1'b0;
                    r_bflag    <= 1'b0;
                end
            end

            if (r_state == ST_WIN_EV) begin
                if (pair_hit && (r_k == '0) && (r_fill == WIN_FILL_W'(WIN_DEPTH))) begin
                    r_wflag <= 1'b1;
                end
                if (pair_hit && bin_past) begin
                    r_bflag <= 1'b1;
                end
                if (!(pair_hit && !bin_past)) begin
                    r_k <= r_k + WIN_AW'(1);
                end
            end

            if (r_state == ST_BIN_WR) begin
                r_k <= r_k + WIN_AW'(1);
            end

            if (r_state == ST_STORE) begin
                r_head <= (r_head == WIN_AW'(WIN_DEPTH - 1)) ? '0 : r_head + WIN_AW'(1);
                if (r_fill != WIN_FILL_W'(WIN_DEPTH)) begin
                    r_fill <= r_fill + WIN_FILL_W'(1);
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_chrom   <= i_chromosome;
            r_pos     <= i_position;
            r_gt      <= i_genotype[EG_W-1:0];
            r_sel     <= i_bin_select;
            r_res_pc  <= '0;
            r_res_sp  <= '0;
            r_res_sa  <= '0;
            r_res_sb  <= '0;
            r_res_cov <= '0;
            r_res_cv  <= 1'b0;
        end

        if (r_state == ST_WIN_EV) begin
            r_eg   <= e_gt;
            r_drem <= delta[MD_W-1:0];
            r_dsor <= (BW_W+BIN_AW)'({bw_eff, {(BIN_AW-1){1'b0}}});
            r_quo  <= '0;
            r_dcnt <= '0;
        end

        if (r_state == ST_BIN_DIV) begin
            if (div_ge) begin
                r_drem <= r_drem - r_dsor[MD_W-1:0];
            end
            r_dsor <= r_dsor >> 1;
            r_quo  <= {r_quo[BIN_AW-2:0], div_ge};
            r_dcnt <= r_dcnt + DCNT_W'(1);
        end

        if ((r_state == ST_READ_EV) && sel_ok) begin
            r_res_pc <= b_pc;
            r_res_sp <= b_sp;
            r_res_sa <= b_sa;
            r_res_sb <= b_sb;
        end

        if ((r_state == ST_COV) && cov_done) begin
            r_res_cov <= cov_val;
            r_res_cv  <= 1'b1;
        end

        if (out_load) begin
            r_out_pc  <= r_res_pc;
            r_out_sp  <= r_res_sp;
            r_out_sa  <= r_res_sa;
            r_out_sb  <= r_res_sb;
            r_out_cov <= r_res_cov;
            r_out_cv  <= r_res_cv;
            r_out_wf  <= r_wflag;
            r_out_bf  <= r_bflag;
        end
    end

    assign o_in_ready         = (r_state == ST_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_pair_count       = r_out_pc;
    assign o_sum_product      = r_out_sp;
    assign o_sum_first        = r_out_sa;
    assign o_sum_second       = r_out_sb;
    assign o_covariance       = r_out_cov;
    assign o_covariance_valid = r_out_cv;
    assign o_window_overflow  = r_out_wf;
    assign o_bin_overflow     = r_out_bf;

endmodule
`default_nettype wire

FILE: hw/rtl/bpc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

FILE: hw/rtl/bpc_cov.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bpc_cov
// Sequential covariance unit: shift-add products, then restoring division
// of (n*Sab - Sa*Sb) << 16 by n*(n-1), rounded and saturated to Q16.
// ----------------------------------------------------------------------------
module bpc_cov (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_start,
    input  wire logic        [bpc_pkg::PC_W-1:0] i_pairs,
    input  wire logic        [bpc_pkg::SP_W-1:0] i_sum_product,
    input  wire logic        [bpc_pkg::SF_W-1:0] i_sum_first,
    input  wire logic        [bpc_pkg::SF_W-1:0] i_sum_second,
    output logic                                o_done,
    output logic signed     [bpc_pkg::COV_W-1:0] o_covariance
);
    import bpc_pkg::*;

    localparam int MUL_STEPS = SF_W;
    localparam int PROD_W    = SP_W + SF_W;
    localparam int MAG_W     = PC_W + SP_W;
    localparam int DEN_W     = 2 * PC_W;
    localparam int NUM_W     = MAG_W + 16;
    localparam int Q_W       = COV_W + 1;

    t_cov_state r_state, n_state;

    logic [PROD_W-1:0]        r_mcand;
    logic [MUL_STEPS-1:0]     r_mplier;
    logic [PROD_W-1:0]        r_prod;
    logic [6:0]               r_cnt;
    logic [MAG_W-1:0]         r_a;
    logic [MAG_W-1:0]         r_mag;
    logic                     r_neg;
    logic [DEN_W-1:0]         r_den;
    logic [NUM_W-1:0]         r_num;
    logic [DEN_W-1:0]         r_rem;
    logic [Q_W-1:0]           r_q;
    logic                     r_big;
    logic signed [COV_W-1:0]  r_cov;
    logic                     r_done;

    logic                     mul_last;
    logic                     div_last;
    logic [DEN_W:0]           div_t;
    logic                     div_ge;
    logic                     rnd_up;
    logic [Q_W:0]             q_rnd;
    logic [Q_W-1:0]           q_cap;
    logic signed [COV_W-1:0]  cov_val;

    assign mul_last = (r_cnt == 7'(MUL_STEPS - 1));
    assign div_last = (r_cnt == 7'(NUM_W - 1));
    assign div_t    = {r_rem, r_num[NUM_W-1]};
    assign div_ge   = (div_t >= {1'b0, r_den});
    assign rnd_up   = ({r_rem, 1'b0} >= {1'b0, r_den});
    assign q_rnd    = {1'b0, r_q} + (Q_W+1)'(rnd_up);

    always_comb begin
        if (r_big || q_rnd > (Q_W+1)'(1 << COV_W)) begin
            q_cap = Q_W'(1 << COV_W);
        end else begin
            q_cap = q_rnd[Q_W-1:0];
        end
        if (r_neg) begin
            if (q_cap > Q_W'(1 << (COV_W-1))) begin
                cov_val = COV_W'(1 << (COV_W-1));
            end else begin
                cov_val = -$signed(q_cap[COV_W-1:0]);
            end
        end else begin
            if (q_cap > Q_W'((1 << (COV_W-1)) - 1)) begin
                cov_val = COV_W'((1 << (COV_W-1)) - 1);
            end else begin
                cov_val = $signed(q_cap[COV_W-1:0]);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            CV_IDLE:   if (i_start) n_state = CV_MUL_A;
            CV_MUL_A:  if (mul_last) n_state = CV_SAVE_A;
            CV_SAVE_A: n_state = CV_MUL_B;
            CV_MUL_B:  if (mul_last) n_state = CV_SAVE_B;
            CV_SAVE_B: n_state = CV_MUL_D;
            CV_MUL_D:  if (mul_last) n_state = CV_SAVE_D;
            CV_SAVE_D: n_state = CV_DIV;
            CV_DIV:    if (div_last) n_state = CV_ROUND;
            CV_ROUND:  n_state = CV_IDLE;
            default:   n_state = CV_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= CV_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == CV_ROUND);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            CV_IDLE: begin
                r_mcand  <= PROD_W'(i_sum_product);
                r_mplier <= MUL_STEPS'(i_pairs);
                r_prod   <= '0;
                r_cnt    <= '0;
            end
            CV_MUL_A, CV_MUL_B, CV_MUL_D: begin
                if (r_mplier[0]) begin
                    r_prod <= r_prod + r_mcand;
                end
                r_mcand  <= r_mcand << 1;
                r_mplier <= r_mplier >> 1;
                r_cnt    <= r_cnt + 7'd1;
            end
            CV_SAVE_A: begin
                r_a      <= r_prod[MAG_W-1:0];
                r_mcand  <= PROD_W'(i_sum_first);
                r_mplier <= i_sum_second;
                r_prod   <= '0;
                r_cnt    <= '0;
            end
            CV_SAVE_B: begin
                r_neg    <= (r_a < r_prod[MAG_W-1:0]);
                r_mag    <= (r_a < r_prod[MAG_W-1:0]) ? r_prod[MAG_W-1:0] - r_a
                                                      : r_a - r_prod[MAG_W-1:0];
                r_mcand  <= PROD_W'(i_pairs);
                r_mplier <= MUL_STEPS'(i_pairs - PC_W'(1));
                r_prod   <= '0;
                r_cnt    <= '0;
            end
            CV_SAVE_D: begin
                r_den <= r_prod[DEN_W-1:0];
                r_num <= {r_mag, 16'b0};
                r_rem <= '0;
                r_q   <= '0;
                r_big <= 1'b0;
                r_cnt <= '0;
            end
            CV_DIV: begin
                r_rem <= div_ge ? DEN_W'(div_t - {1'b0, r_den}) : div_t[DEN_W-1:0];
                r_num <= r_num << 1;
                r_q   <= {r_q[Q_W-2:0], div_ge};
                r_big <= r_big | r_q[Q_W-1];
                r_cnt <= r_cnt + 7'd1;
            end
            CV_ROUND: begin
                r_cov <= cov_val;
            end
            default: begin
                r_cnt <= '0;
            end
        endcase
    end

    assign o_done       = r_done;
    assign o_covariance = r_cov;

endmodule
`default_nettype wire
